// ===== hw/rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants for the bitmap slot allocator
// Request modes, status codes, fixed field widths and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 10;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_SET        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_FREE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALLOC_FREE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIND_USED  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_REL_USED   = 3'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Slot count after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // take a request and launch the word read
    logic commit;  // finish the request: update the word, load the result
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top: allocation bitmap with lowest-slot search
// Set, clear, check, find/allocate lowest free and find/release lowest used
// slot over a word-organized bitmap, one result per request.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      mode, slot_index
//   m_axis    out        m_axis_tvalid/tready      status, result_index,
//                                                  bit_was_set
//   cfg       in         cfg_valid_i/cfg_ready_o   item_count
//
// Each request is handled in order: the load step selects the word (per-word full and
// empty flags through a priority encoder) and reads it from the word memory,
// then the execute step finds the bit, checks the range and writes the word back.
// The result register lets a new request in while the last result waits;
// a request whose result cannot be loaded holds in the execute step.
// Reset clears the flags at once, so every slot reads free with no clearing
// pass; item_count resets to 1024. The config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_top #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // [2:0] mode, [12:3] slot_index, [15:13] zero
  input  wire logic [bsa_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [1:0] status, [11:2] result_index, [12] bit_was_set, [15:13] zero
  output logic      [bsa_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bsa_pkg::CNT_W-1:0]          cfg_data_i
);
  import bsa_pkg::*;

  cmd_t                cmd;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   slot_index;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   result_index;
  logic                bit_was_set;

  // Unpack the request
  assign mode       = s_axis_tdata[MODE_W-1:0];
  assign slot_index = s_axis_tdata[MODE_W+SLOT_W-1:MODE_W];

  assign cfg_ready_o = 1'b1;

  bsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  bsa_datapath #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode),
    .slot_index_i   (slot_index),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .status_o       (status),
    .result_index_o (result_index),
    .bit_was_set_o  (bit_was_set)
  );

  // Pack the result
  assign m_axis_tdata = {
    {(OUT_DATA_W - STATUS_W - SLOT_W - 1){1'b0}},
    bit_was_set,
    result_index,
    status
  };

endmodule

`default_nettype wire

// ===== hw/rtl/bsa_first_one.sv =====
// ----------------------------------------------------------------------------
// bsa_first_one: priority encoder
// Returns the position of the lowest set bit of a vector and a found flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_first_one #(
  parameter int W  = 32,
  parameter int IW = (W > 1) ? $clog2(W) : 1
) (
  input  wire logic [W-1:0]  vec_i,
  output logic               found_o,
  output logic [IW-1:0]      idx_o
);

  // Scan from the top so the lowest set bit wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsa_ctrl: request sequencer
// Two-state controller: take a request and start the word read, then commit
// the word update and result once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output bsa_pkg::cmd_t    cmd_o
);
  import bsa_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // Output register is free when empty or being drained this cycle
  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  assign cmd_o.load   = (state_q == ST_IDLE) && s_valid_i;
  assign cmd_o.commit = (state_q == ST_EXEC) && out_free;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Track the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bsa_datapath.sv =====
// ----------------------------------------------------------------------------
// bsa_datapath: bitmap storage and search logic
// Word memory with per-word full/empty flags, word and bit priority
// encoders, range checks, read-modify-write and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath #(
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bsa_pkg::cmd_t                   cmd_i,
  input  wire logic [bsa_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [bsa_pkg::SLOT_W-1:0]      slot_index_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [bsa_pkg::CNT_W-1:0]       cfg_data_i,
  output logic      [bsa_pkg::STATUS_W-1:0]    status_o,
  output logic      [bsa_pkg::SLOT_W-1:0]      result_index_o,
  output logic                                 bit_was_set_o
);
  import bsa_pkg::*;

  // WORD_BITS must be a power of two; the block does not enforce it
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int SW        = AW + BIT_W;
  localparam int CW        = ((SW > CNT_W) ? SW : CNT_W) + 1;

  // Storage and flags
  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] full_q, full_d;
  logic [NUM_WORDS-1:0] empty_q, empty_d;
  logic [CNT_W-1:0]     item_count_q;

  // Latched request
  logic [MODE_W-1:0]    mode_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [AW-1:0]        word_q;
  logic                 word_hit_q;
  logic [WORD_BITS-1:0] rdata_q;

  // Result register
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [SLOT_W-1:0]    result_q, result_d;
  logic                 was_q, was_d;

  // Request decode at load time
  logic                 s_search, s_want;
  logic [NUM_WORDS-1:0] word_vec;
  logic                 word_found;
  logic [AW-1:0]        word_idx;
  logic [AW-1:0]        rd_addr;

  // Execute stage
  logic                 e_direct, e_search, e_want;
  logic [WORD_BITS-1:0] cur_word, new_word, bit_vec;
  logic                 bit_found;
  logic [BIT_W-1:0]     bit_idx, bit_pos;
  logic [CW-1:0]        eff_count, cnt_ext, slot_ext, found_ext;
  logic                 direct_ok, search_ok;
  logic                 wr_en, wr_val;

  // Pick the word to read
  assign s_search = (mode_i inside {MODE_FIND_FREE, MODE_ALLOC_FREE,
                                    MODE_FIND_USED, MODE_REL_USED});
  assign s_want   = (mode_i inside {MODE_FIND_USED, MODE_REL_USED});
  assign word_vec = s_want ? ~empty_q : ~full_q;

  bsa_first_one #(
    .W  (NUM_WORDS),
    .IW (AW)
  ) u_word_enc (
    .vec_i   (word_vec),
    .found_o (word_found),
    .idx_o   (word_idx)
  );

  assign rd_addr = s_search ? word_idx : AW'(slot_index_i >> BIT_W);

  // Latch the request and read the word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      slot_q     <= slot_index_i;
      word_q     <= rd_addr;
      word_hit_q <= word_found;
      rdata_q    <= mem_q[rd_addr];
    end
  end

  // Current word: an empty word may never have been written
  assign e_direct = (mode_q inside {MODE_SET, MODE_CLEAR, MODE_CHECK});
  assign e_search = (mode_q inside {MODE_FIND_FREE, MODE_ALLOC_FREE,
                                    MODE_FIND_USED, MODE_REL_USED});
  assign e_want   = (mode_q inside {MODE_FIND_USED, MODE_REL_USED});
  assign cur_word = empty_q[word_q] ? '0 : rdata_q;
  assign bit_vec  = e_want ? cur_word : ~cur_word;

  bsa_first_one #(
    .W  (WORD_BITS),
    .IW (BIT_W)
  ) u_bit_enc (
    .vec_i   (bit_vec),
    .found_o (bit_found),
    .idx_o   (bit_idx)
  );

  // Range checks against the effective slot count
  assign cnt_ext   = CW'(item_count_q);
  assign eff_count = (cnt_ext > CW'(MAX_BITS)) ? CW'(MAX_BITS) : cnt_ext;
  assign slot_ext  = CW'(slot_q);
  assign found_ext = CW'({word_q, bit_idx});
  assign direct_ok = slot_ext < eff_count;
  assign search_ok = word_hit_q && bit_found && (found_ext < eff_count);

  // Modify the word
  assign bit_pos = e_direct ? slot_q[BIT_W-1:0] : bit_idx;
  assign wr_val  = (mode_q == MODE_SET) || (mode_q == MODE_ALLOC_FREE);
  assign wr_en   = cmd_i.commit &&
                   ((direct_ok && ((mode_q == MODE_SET) || (mode_q == MODE_CLEAR))) ||
                    (search_ok && ((mode_q == MODE_ALLOC_FREE) ||
                                   (mode_q == MODE_REL_USED))));

  always_comb begin
    new_word          = cur_word;
    new_word[bit_pos] = wr_val;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[word_q] <= new_word;
    end
  end

  // Refresh the word flags
  always_comb begin
    full_d  = full_q;
    empty_d = empty_q;
    if (wr_en) begin
      full_d[word_q]  = &new_word;
      empty_d[word_q] = ~|new_word;
    end
  end

  // Build the result
  always_comb begin
    status_d = STATUS_RANGE_ERR;
    result_d = slot_q;
    was_d    = 1'b0;
    if (e_direct) begin
      if (direct_ok) begin
        status_d = STATUS_OK;
        was_d    = cur_word[bit_pos];
      end
    end else if (e_search) begin
      if (search_ok) begin
        status_d = STATUS_OK;
        result_d = SLOT_W'(found_ext);
        was_d    = e_want;
      end else begin
        status_d = STATUS_NOT_FOUND;
        result_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      result_q <= result_d;
      was_q    <= was_d;
    end
  end

  // Flags and slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q       <= '0;
      empty_q      <= '1;
      item_count_q <= COUNT_RESET;
    end else begin
      full_q  <= full_d;
      empty_q <= empty_d;
      if (cfg_we_i) begin
        item_count_q <= cfg_data_i;
      end
    end
  end

  assign status_o       = status_q;
  assign result_index_o = result_q;
  assign bit_was_set_o  = was_q;

endmodule

`default_nettype wire
